// File: rtl/core/icrs_pkg.sv
// Shared types and constants for the imager capture/readout sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package icrs_pkg;

  // Power states, also the encoding reported in power_state
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_IMAGING = 2'd2,
    MODE_READOUT = 2'd3
  } mode_t;

  // Function codes of an input word (code 3 only reports status)
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_CLAIM   = 2'd1;
  localparam logic [1:0] FUNC_DEQUEUE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_VOLTAGE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IMAGING_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_READOUT_PERIOD    = 2'd2;
  localparam logic [1:0] CFG_START_STATE       = 2'd3;

  localparam logic [15:0] VTH_RST         = 16'd5000;
  localparam logic [23:0] IMG_PERIOD_RST  = 24'd31260;
  localparam logic [23:0] RD_PERIOD_RST   = 24'd838860;
  localparam logic [1:0]  START_STATE_RST = MODE_OFF;

  localparam logic [11:0] MW_IMAGING = 12'd3500;
  localparam logic [11:0] MW_READOUT = 12'd2500;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] job_id;
    logic [23:0] elapsed_us;
    logic [15:0] supply_mv;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  power_state;
    logic [11:0] power_mw;
    logic        image_valid;
    logic [15:0] image_id;
    logic [4:0]  claimed_count;
    logic [4:0]  ready_count;
    logic [4:0]  dropped_count;
    logic        claim_rejected;
  } out_item_t;

  typedef struct packed {
    logic [15:0] voltage_threshold_mv;
    logic [23:0] imaging_period_us;
    logic [23:0] readout_period_us;
    logic [1:0]  start_state;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic init;      // load mode from start_state
    logic load;      // capture input word
    logic exec;      // perform the function
    logic adv;       // one period-subtraction step
    logic out_load;  // fill the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_adv;
    logic adv_done;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/icrs_ctrl.sv
// Sequencing state machine of the capture/readout sequencer.
// Depends on icrs_pkg; drives commands into icrs_dpath.
`default_nettype none

module icrs_ctrl import icrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_EXEC = 5'b00100,
    S_ADV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.need_adv ? S_ADV : S_OUT;
      end
      S_ADV: begin
        cmd.adv = 1'b1;
        if (status.adv_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // wait until the previous word has left the result register
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/icrs_dpath.sv
// Datapath of the capture/readout sequencer: job ring, pointers, mode,
// accumulators and result register. Depends on icrs_pkg; driven by icrs_ctrl.
`default_nettype none

module icrs_dpath import icrs_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output status_t   status,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int PW = $clog2(2 * QUEUE_DEPTH);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(QUEUE_DEPTH);
  localparam logic [PW:0]   PTR_MOD  = (PW + 1)'(2 * QUEUE_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] to_p,
                                             input logic [PW-1:0] from_p);
    logic [PW:0] diff;
    diff = {1'b0, to_p} - {1'b0, from_p};
    if (to_p < from_p) diff = diff + PTR_MOD;
    ptr_dist = diff[PW-1:0];
  endfunction

  function automatic logic [IW-1:0] ptr_idx(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = (p >= DEPTH_P) ? p - DEPTH_P : p;
    ptr_idx = q[IW-1:0];
  endfunction

  in_item_t  item_r, item_nxt;
  mode_t     mode_r, mode_nxt;
  logic [PW-1:0] ready_head_r, ready_head_nxt;
  logic [PW-1:0] readout_head_r, readout_head_nxt;
  logic [PW-1:0] imaging_head_r, imaging_head_nxt;
  logic [PW-1:0] ring_tail_r, ring_tail_nxt;
  logic [24:0] img_acc_r, img_acc_nxt;
  logic [24:0] rd_acc_r, rd_acc_nxt;
  logic        image_valid_r, image_valid_nxt;
  logic [15:0] image_id_r, image_id_nxt;
  logic [4:0]  dropped_r, dropped_nxt;
  logic        rejected_r, rejected_nxt;
  out_item_t   out_r, out_nxt;

  logic [15:0] ring [QUEUE_DEPTH];
  logic [15:0] rdata_r;

  logic good, is_tick, img_step, rd_step, ring_full, ring_we;
  logic [11:0] mw;

  assign good     = item_r.supply_mv >= cfg.voltage_threshold_mv;
  assign is_tick  = (item_r.func == FUNC_TICK);
  assign img_step = (imaging_head_r != ring_tail_r) &&
                    (img_acc_r >= {1'b0, cfg.imaging_period_us});
  assign rd_step  = (readout_head_r != imaging_head_r) &&
                    (rd_acc_r >= {1'b0, cfg.readout_period_us});
  // ready images share the ring, so fullness counts from ready_head
  assign ring_full = ptr_dist(ring_tail_r, ready_head_r) >= DEPTH_P;
  assign ring_we   = cmd.exec && (item_r.func == FUNC_CLAIM) && !ring_full;

  assign status.need_adv = is_tick && good &&
                           (mode_r == MODE_IMAGING || mode_r == MODE_READOUT);
  assign status.adv_done = (mode_r == MODE_IMAGING) ? !img_step : !rd_step;

  always_comb begin
    case (mode_r)
      MODE_IMAGING: mw = MW_IMAGING;
      MODE_READOUT: mw = MW_READOUT;
      default:      mw = '0;
    endcase
  end

  always_comb begin
    item_nxt         = item_r;
    mode_nxt         = mode_r;
    ready_head_nxt   = ready_head_r;
    readout_head_nxt = readout_head_r;
    imaging_head_nxt = imaging_head_r;
    ring_tail_nxt    = ring_tail_r;
    img_acc_nxt      = img_acc_r;
    rd_acc_nxt       = rd_acc_r;
    image_valid_nxt  = image_valid_r;
    image_id_nxt     = image_id_r;
    dropped_nxt      = dropped_r;
    rejected_nxt     = rejected_r;
    out_nxt          = out_r;

    if (cmd.init) begin
      mode_nxt = mode_t'(cfg.start_state);
    end

    if (cmd.load) begin
      item_nxt        = in_data;
      image_valid_nxt = 1'b0;
      image_id_nxt    = '0;
      dropped_nxt     = '0;
      rejected_nxt    = 1'b0;
    end

    if (cmd.exec) begin
      case (item_r.func)
        FUNC_TICK: begin
          unique case (mode_r)
            MODE_OFF: begin
              if (good) begin
                mode_nxt = (readout_head_r != imaging_head_r) ? MODE_READOUT : MODE_IDLE;
              end
            end
            MODE_IDLE: begin
              if (!good) begin
                mode_nxt = MODE_OFF;
              end else if (imaging_head_r != ring_tail_r) begin
                mode_nxt = MODE_IMAGING;
              end
            end
            MODE_IMAGING: begin
              if (!good) begin
                // brownout drops every job still waiting for capture
                dropped_nxt   = 5'(ptr_dist(ring_tail_r, imaging_head_r));
                ring_tail_nxt = imaging_head_r;
                img_acc_nxt   = '0;
                mode_nxt      = MODE_OFF;
              end else begin
                img_acc_nxt = img_acc_r + 25'(item_r.elapsed_us);
              end
            end
            MODE_READOUT: begin
              if (!good) begin
                mode_nxt = MODE_OFF;
              end else begin
                rd_acc_nxt = rd_acc_r + 25'(item_r.elapsed_us);
              end
            end
            default: mode_nxt = mode_r;
          endcase
        end
        FUNC_CLAIM: begin
          if (ring_full) begin
            rejected_nxt = 1'b1;
          end else begin
            ring_tail_nxt = ptr_inc(ring_tail_r);
          end
        end
        FUNC_DEQUEUE: begin
          if (ready_head_r != readout_head_r) begin
            image_valid_nxt = 1'b1;
            image_id_nxt    = rdata_r;
            ready_head_nxt  = ptr_inc(ready_head_r);
          end
        end
        default: ;
      endcase
    end

    // one job per cycle; on the last cycle an emptied region changes the mode
    if (cmd.adv) begin
      if (mode_r == MODE_IMAGING) begin
        if (img_step) begin
          imaging_head_nxt = ptr_inc(imaging_head_r);
          img_acc_nxt      = img_acc_r - {1'b0, cfg.imaging_period_us};
        end else if (imaging_head_r == ring_tail_r) begin
          img_acc_nxt = '0;
          mode_nxt    = MODE_READOUT;
        end
      end else begin
        if (rd_step) begin
          readout_head_nxt = ptr_inc(readout_head_r);
          rd_acc_nxt       = rd_acc_r - {1'b0, cfg.readout_period_us};
        end else if (readout_head_r == imaging_head_r) begin
          rd_acc_nxt = '0;
          mode_nxt   = MODE_IDLE;
        end
      end
    end

    if (cmd.out_load) begin
      out_nxt.power_state    = mode_r;
      out_nxt.power_mw       = mw;
      out_nxt.image_valid    = image_valid_r;
      out_nxt.image_id       = image_id_r;
      out_nxt.claimed_count  = 5'(ptr_dist(ring_tail_r, readout_head_r));
      out_nxt.ready_count    = 5'(ptr_dist(readout_head_r, ready_head_r));
      out_nxt.dropped_count  = dropped_r;
      out_nxt.claim_rejected = rejected_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_OFF;
      ready_head_r   <= '0;
      readout_head_r <= '0;
      imaging_head_r <= '0;
      ring_tail_r    <= '0;
      img_acc_r      <= '0;
      rd_acc_r       <= '0;
    end else begin
      mode_r         <= mode_nxt;
      ready_head_r   <= ready_head_nxt;
      readout_head_r <= readout_head_nxt;
      imaging_head_r <= imaging_head_nxt;
      ring_tail_r    <= ring_tail_nxt;
      img_acc_r      <= img_acc_nxt;
      rd_acc_r       <= rd_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    image_valid_r <= image_valid_nxt;
    image_id_r    <= image_id_nxt;
    dropped_r     <= dropped_nxt;
    rejected_r    <= rejected_nxt;
    out_r         <= out_nxt;
  end

  // job ring: one write port at the tail, registered read at ready_head
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ptr_idx(ring_tail_r)] <= item_r.job_id;
    end
    rdata_r <= ring[ptr_idx(ready_head_r)];
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: rtl/core/imager_capture_readout_sequencer.sv
// Top level of the imager capture/readout sequencer: configuration registers,
// controller and datapath. Depends on icrs_pkg, icrs_ctrl and icrs_dpath.
`default_nettype none

// Power and job sequencer for an imaging sensor. Job ids sit in one ring of
// QUEUE_DEPTH entries split into capture, readout and ready regions; the mode
// is off, idle, imaging or readout. Each input word is a tick, a claim or a
// dequeue and yields exactly one result word. Words are handled one at a
// time: claim, dequeue, status-only words and ticks that do not run the
// period loop (off, idle, or a brownout) go from accept through execute
// and result load back to accept. A tick in imaging or readout with a
// good supply runs the period-subtraction loop between execute and result
// load, one job per cycle and then a closing step; at most QUEUE_DEPTH
// jobs move. A result word still stalled at the output holds the result
// load while it waits.
// The cycle after reset loads the mode from start_state; no word is taken
// then. The config port is always ready and must only be written while idle.
module imager_capture_readout_sequencer import icrs_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_VOLTAGE_THRESHOLD: cfg_nxt.voltage_threshold_mv = cfg_wdata[15:0];
        CFG_IMAGING_PERIOD:    cfg_nxt.imaging_period_us    = cfg_wdata;
        CFG_READOUT_PERIOD:    cfg_nxt.readout_period_us    = cfg_wdata;
        CFG_START_STATE:       cfg_nxt.start_state          = cfg_wdata[1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_threshold_mv <= VTH_RST;
      cfg_r.imaging_period_us    <= IMG_PERIOD_RST;
      cfg_r.readout_period_us    <= RD_PERIOD_RST;
      cfg_r.start_state          <= START_STATE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  icrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  icrs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // one word in flight: after an accept the input side stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // a result word is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register loaded while stalled");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.init, cmd.load, cmd.exec, cmd.adv, cmd.out_load}))
    else $error("controller issued more than one command");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for imager_capture_readout_sequencer: a directed part,
// then randomized phases under several register settings, checked against a
// built-in predictor of the job ring and power modes. Depends on icrs_pkg.

module testbench;
  import icrs_pkg::*;

  localparam logic [1:0] FUNC_STATUS = 2'd3;   // no-op, status only
  localparam int RING_DEPTH = 16;
  localparam int DUE_DEPTH = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  imager_capture_readout_sequencer #(.QUEUE_DEPTH(RING_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: register copies, job ring, pointers, mode, accumulators
  logic [15:0] vth;
  logic [23:0] img_per;
  logic [23:0] rd_per;
  logic [15:0] ring_ids [RING_DEPTH];
  logic [4:0]  rdy_hd, rdo_hd, img_hd, tail;
  mode_t       pwr_mode;
  logic [24:0] img_acc, rdo_acc;

  // expected result words, written at accept and read at the result side
  out_item_t   due_words [DUE_DEPTH];
  int          due_wr;
  int          due_rd;
  out_item_t   due_w;
  int          mismatches;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Status word for one input word; updates the predictor state
  task automatic next_status(input in_item_t w, output out_item_t r);
    logic        good;
    logic [4:0]  drop;
    logic        rej;
    logic        taken;
    logic [15:0] img;
    logic [25:0] acc;
    drop = '0;
    rej = 1'b0;
    taken = 1'b0;
    img = '0;
    good = (w.supply_mv >= vth);
    case (w.func)
      FUNC_TICK: begin
        case (pwr_mode)
          MODE_OFF: begin
            // no time accumulates on the wake-up tick
            if (good) pwr_mode = (rdo_hd != img_hd) ? MODE_READOUT : MODE_IDLE;
          end
          MODE_IDLE: begin
            if (!good) pwr_mode = MODE_OFF;
            else if (img_hd != tail) pwr_mode = MODE_IMAGING;
          end
          MODE_IMAGING: begin
            if (!good) begin
              // brownout drops every job still waiting for capture
              drop = 5'(tail - img_hd);
              tail = img_hd;
              img_acc = '0;
              pwr_mode = MODE_OFF;
            end else begin
              acc = img_acc + w.elapsed_us;
              while (img_hd != tail && acc >= img_per) begin
                img_hd = img_hd + 5'd1;
                acc = acc - img_per;
              end
              img_acc = acc[24:0];
              if (img_hd == tail) begin
                img_acc = '0;
                pwr_mode = MODE_READOUT;
              end
            end
          end
          default: begin
            // readout brownout keeps both the region and the accumulator
            if (!good) begin
              pwr_mode = MODE_OFF;
            end else begin
              acc = rdo_acc + w.elapsed_us;
              while (rdo_hd != img_hd && acc >= rd_per) begin
                rdo_hd = rdo_hd + 5'd1;
                acc = acc - rd_per;
              end
              rdo_acc = acc[24:0];
              if (rdo_hd == img_hd) begin
                rdo_acc = '0;
                pwr_mode = MODE_IDLE;
              end
            end
          end
        endcase
      end
      FUNC_CLAIM: begin
        // ready images hold ring entries too
        if (5'(tail - rdy_hd) >= 5'(RING_DEPTH)) begin
          rej = 1'b1;
        end else begin
          ring_ids[tail[3:0]] = w.job_id;
          tail = tail + 5'd1;
        end
      end
      FUNC_DEQUEUE: begin
        if (rdy_hd != rdo_hd) begin
          taken = 1'b1;
          img = ring_ids[rdy_hd[3:0]];
          rdy_hd = rdy_hd + 5'd1;
        end
      end
      default: ;
    endcase
    r.power_state    = pwr_mode;
    r.power_mw       = (pwr_mode == MODE_IMAGING) ? MW_IMAGING :
                       (pwr_mode == MODE_READOUT) ? MW_READOUT : 12'd0;
    r.image_valid    = taken;
    r.image_id       = img;
    r.claimed_count  = 5'(tail - rdo_hd);
    r.ready_count    = 5'(rdo_hd - rdy_hd);
    r.dropped_count  = drop;
    r.claim_rejected = rej;
  endtask

  // Sends one word; valid stays high afterwards until the next gap or drain
  task automatic send_word(input logic [1:0] func, input logic [15:0] id,
                           input logic [23:0] elapsed, input logic [15:0] supply);
    in_item_t  w;
    out_item_t r;
    w.func = func;
    w.job_id = id;
    w.elapsed_us = elapsed;
    w.supply_mv = supply;
    while (gaps_on && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    next_status(w, r);
    due_words[due_wr % DUE_DEPTH] = r;
    due_wr++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_wr != due_rd);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      CFG_VOLTAGE_THRESHOLD: vth = data[15:0];
      CFG_IMAGING_PERIOD:    img_per = data;
      CFG_READOUT_PERIOD:    rd_per = data;
      default:               ;   // start state only matters at reset
    endcase
    @(negedge clk);
  endtask

  // Only called with every result in, so the block is idle
  task automatic program_regs(input logic [23:0] v, input logic [23:0] ip,
                              input logic [23:0] rp, input logic [23:0] ss);
    write_reg(CFG_VOLTAGE_THRESHOLD, v);
    write_reg(CFG_IMAGING_PERIOD, ip);
    write_reg(CFG_READOUT_PERIOD, rp);
    write_reg(CFG_START_STATE, ss);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_supply();
    if (vth != 16'd0 && $urandom_range(0, 99) < 15)
      return 16'($urandom_range(0, vth - 1));
    return 16'($urandom_range(vth, 16'hFFFF));
  endfunction

  // Elapsed time scaled to the period of the current mode, plus extremes
  function automatic logic [23:0] pick_elapsed();
    int unsigned p;
    int unsigned v;
    int unsigned sel;
    p = (pwr_mode == MODE_READOUT) ? rd_per : img_per;
    sel = $urandom_range(0, 99);
    if (sel < 8) return 24'd0;
    if (sel < 16) return 24'hFFFFFF;
    if (sel < 28) return 24'($urandom);
    v = $urandom_range(0, 2 * p);
    return (v > 32'hFFFFFF) ? 24'hFFFFFF : 24'(v);
  endfunction

  task automatic random_phase(input int n, input int claim_pct, input int deq_pct);
    int          sel;
    logic [1:0]  func;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < claim_pct) func = FUNC_CLAIM;
      else if (sel < claim_pct + deq_pct) func = FUNC_DEQUEUE;
      else if (sel < claim_pct + deq_pct + 4) func = FUNC_STATUS;
      else func = FUNC_TICK;
      send_word(func, 16'($urandom), pick_elapsed(), pick_supply());
    end
    drain_results();
  endtask

  task automatic test_reset_defaults();
    send_word(FUNC_STATUS, 16'h1234, 24'hABCDEF, 16'h0);
    send_word(FUNC_DEQUEUE, 16'h0, 24'h0, 16'h0);              // empty dequeue
    send_word(FUNC_CLAIM, 16'hFFFF, 24'h0, 16'h0);
    send_word(FUNC_CLAIM, 16'h0000, 24'h0, 16'h0);
    send_word(FUNC_TICK, 16'h0, 24'h0, VTH_RST - 16'd1);      // stays off
    send_word(FUNC_TICK, 16'h0, 24'hFFFFFF, VTH_RST);         // off -> idle
    send_word(FUNC_TICK, 16'h0, 24'h0, 16'hFFFF);             // idle -> imaging
    send_word(FUNC_TICK, 16'h0, IMG_PERIOD_RST, 16'hFFFF);    // one job captured
    send_word(FUNC_TICK, 16'h0, 24'h0, 16'h0);                // brownout drops one
    send_word(FUNC_TICK, 16'h0, 24'h0, VTH_RST);              // off -> readout
    send_word(FUNC_TICK, 16'h0, RD_PERIOD_RST - 24'd1, VTH_RST);
    send_word(FUNC_TICK, 16'h0, 24'h0, 16'd1);                // readout brownout
    send_word(FUNC_TICK, 16'h0, 24'h0, VTH_RST);
    send_word(FUNC_TICK, 16'h0, 24'd1, VTH_RST);              // kept time completes
    send_word(FUNC_DEQUEUE, 16'h0, 24'h0, 16'h0);
    drain_results();
  endtask

  task automatic test_full_ring_zero_period();
    program_regs(24'h00FFFF, 24'h0, 24'h0, {22'h0, MODE_READOUT});
    for (int i = 0; i <= RING_DEPTH; i++)
      send_word(FUNC_CLAIM, 16'($urandom), 24'h0, 16'h0);     // last one refused
    send_word(FUNC_TICK, 16'h0, 24'h0, 16'hFFFF);
    send_word(FUNC_TICK, 16'h0, 24'hFFFFFF, 16'hFFFF);        // zero period: all move
    send_word(FUNC_TICK, 16'h0, 24'h0, 16'hFFFF);
    send_word(FUNC_CLAIM, 16'hA5A5, 24'h0, 16'h0);            // ready images fill it
    send_word(FUNC_DEQUEUE, 16'h0, 24'h0, 16'h0);
    send_word(FUNC_DEQUEUE, 16'h0, 24'h0, 16'h0);
    drain_results();
  endtask

  task automatic test_random_default_periods();
    program_regs({8'($urandom), VTH_RST}, IMG_PERIOD_RST, RD_PERIOD_RST,
                 24'($urandom));
    random_phase(120, 25, 15);
  endtask

  task automatic test_random_short_periods();
    program_regs(24'($urandom_range(1000, 60000)), 24'($urandom_range(1, 400)),
                 24'($urandom_range(1, 3000)), 24'($urandom));
    random_phase(120, 40, 10);
  endtask

  task automatic test_random_no_gaps();
    gaps_on = 1'b0;
    program_regs(24'h0, 24'hFFFFFF, 24'($urandom_range(1, 100000)), 24'h0);
    random_phase(120, 25, 20);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_high_threshold();
    program_regs(24'h00FFFF, 24'h0, 24'd1, {22'h0, MODE_IMAGING});
    random_phase(120, 25, 20);
  endtask

  task automatic test_random_mixed();
    program_regs(24'($urandom),
                 $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 5000)),
                 $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 20000)),
                 24'($urandom));
    random_phase(120, 30, 20);
  endtask

  // Result side: random stall, one compare per accepted word
  always @(negedge clk)
    out_stall <= gaps_on && ($urandom_range(0, 99) < 12);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_wr == due_rd) begin
        report_mismatch("word with none expected", out_data.image_id, 16'h0);
      end else begin
        due_w = due_words[due_rd % DUE_DEPTH];
        due_rd++;
        if (out_data.power_state !== due_w.power_state)
          report_mismatch("power_state", out_data.power_state, due_w.power_state);
        if (out_data.power_mw !== due_w.power_mw)
          report_mismatch("power_mw", out_data.power_mw, due_w.power_mw);
        if (out_data.image_valid !== due_w.image_valid)
          report_mismatch("image_valid", out_data.image_valid, due_w.image_valid);
        if (out_data.image_id !== due_w.image_id)
          report_mismatch("image_id", out_data.image_id, due_w.image_id);
        if (out_data.claimed_count !== due_w.claimed_count)
          report_mismatch("claimed_count", out_data.claimed_count, due_w.claimed_count);
        if (out_data.ready_count !== due_w.ready_count)
          report_mismatch("ready_count", out_data.ready_count, due_w.ready_count);
        if (out_data.dropped_count !== due_w.dropped_count)
          report_mismatch("dropped_count", out_data.dropped_count, due_w.dropped_count);
        if (out_data.claim_rejected !== due_w.claim_rejected)
          report_mismatch("claim_rejected", out_data.claim_rejected,
                          due_w.claim_rejected);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = CFG_VOLTAGE_THRESHOLD;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    mismatches = 0;
    due_wr = 0;
    due_rd = 0;
    vth = VTH_RST;
    img_per = IMG_PERIOD_RST;
    rd_per = RD_PERIOD_RST;
    foreach (ring_ids[i]) ring_ids[i] = '0;
    rdy_hd = '0;
    rdo_hd = '0;
    img_hd = '0;
    tail = '0;
    img_acc = '0;
    rdo_acc = '0;
    pwr_mode = MODE_OFF;   // reset clears start_state too
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_full_ring_zero_period();
    test_random_default_periods();
    test_random_short_periods();
    test_random_no_gaps();
    test_random_high_threshold();
    test_random_mixed();

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && due_wr == due_rd)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
